### rtl/isort_pkg.sv
// shared types and constants of the integer array sorter
// no dependencies
`timescale 1ns / 1ps

package isort_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic   ins;
        logic   shift;
        t_value value;
    } t_cell_ctl;

endpackage

### rtl/isort_cell.sv
// one cell of the insertion chain: holds one value and its valid bit
// depends on isort_pkg
`timescale 1ns / 1ps

module isort_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isort_pkg::t_cell_ctl i_ctl,
    input  isort_pkg::t_value   i_prev_value,
    input  logic                i_prev_valid,
    input  logic                i_prev_gt,
    input  isort_pkg::t_value   i_next_value,
    input  logic                i_next_valid,
    output isort_pkg::t_value   o_value,
    output logic                o_valid,
    output logic                o_gt
);

    isort_pkg::t_value r_value;
    isort_pkg::t_value n_value;
    logic              r_valid;
    logic              n_valid;

    // cell must move up when empty or holding a larger value
    assign o_gt    = !r_valid || (r_value > i_ctl.value);
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end else if (i_ctl.ins && o_gt) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else begin
                n_value = i_ctl.value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

### rtl/integer_array_sorter_top.sv
// integer array sorter: control, counters and the chain of sorting cells
// depends on isort_pkg and isort_cell
// load: one request per cycle while busy is low, each value inserted into its sorted place in the cell chain
// drain: starts the cycle after the closing request, one sorted value per cycle for n values
// busy stays high while a set of n values drains, up to and including its final result
// results cannot be stalled: each result holds o_strobe for exactly one cycle
// synchronous active-low reset clears the valid bit of every cell, the counters and the overflow flag
`timescale 1ns / 1ps

module integer_array_sorter_top #(
    parameter int SET_SIZE = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [isort_pkg::VALUE_W-1:0] i_value,
    input  logic                         i_is_last,
    output logic                         o_strobe,
    output logic signed [isort_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                         o_last_out,
    output logic                         o_overflowed
);

    localparam int CNT_W = $clog2(SET_SIZE + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SET_SIZE);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              r_state;
    logic              n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_left;
    logic [CNT_W-1:0]  n_left;
    logic              r_ovf;
    logic              n_ovf;

    logic                 w_accept;
    logic                 w_full;
    isort_pkg::t_cell_ctl w_ctl;

    isort_pkg::t_value w_value [SET_SIZE];
    logic              w_valid [SET_SIZE];
    logic              w_gt    [SET_SIZE];

    assign busy     = (r_state == ST_DRAIN);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_FULL);

    assign w_ctl.ins   = w_accept && !w_full;
    assign w_ctl.shift = (r_state == ST_DRAIN);
    assign w_ctl.value = i_value;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_ovf   = r_ovf;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_ONE;
                    end
                    if (i_is_last) begin
                        n_state = ST_DRAIN;
                        n_left  = w_full ? r_count : r_count + CNT_ONE;
                    end
                end
            end
            ST_DRAIN: begin
                n_left = r_left - CNT_ONE;
                if (r_left == CNT_ONE) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            r_ovf   <= n_ovf;
        end
    end

    for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
        isort_pkg::t_value w_prev_value;
        logic              w_prev_valid;
        logic              w_prev_gt;
        isort_pkg::t_value w_next_value;
        logic              w_next_valid;

        if (i == 0) begin : g_first
            assign w_prev_value = '0;
            assign w_prev_valid = 1'b0;
            assign w_prev_gt    = 1'b0;
        end else begin : g_mid
            assign w_prev_value = w_value[i-1];
            assign w_prev_valid = w_valid[i-1];
            assign w_prev_gt    = w_gt[i-1];
        end

        if (i == SET_SIZE - 1) begin : g_last
            assign w_next_value = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_value = w_value[i+1];
            assign w_next_valid = w_valid[i+1];
        end

        isort_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_value (w_prev_value),
            .i_prev_valid (w_prev_valid),
            .i_prev_gt    (w_prev_gt),
            .i_next_value (w_next_value),
            .i_next_valid (w_next_valid),
            .o_value      (w_value[i]),
            .o_valid      (w_valid[i]),
            .o_gt         (w_gt[i])
        );
    end

    assign o_strobe       = (r_state == ST_DRAIN);
    assign o_sorted_value = w_value[0];
    assign o_last_out     = o_strobe && (r_left == CNT_ONE);
    assign o_overflowed   = o_strobe && r_ovf;

`ifndef SYNTHESIS
    // every result comes from an occupied head cell
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> w_valid[0])
        else $error("result from empty head cell");

    // drain ends only after the final result of the set
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_out) |=> o_strobe)
        else $error("drain stopped before final result");

    // chain is empty once a set has been delivered
    a_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_out |=> (!w_valid[0] && r_count == '0 && !r_ovf))
        else $error("state left over after set");

    // results come out in ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_out) |=> (o_sorted_value >= $past(o_sorted_value)))
        else $error("results out of order");
`endif

endmodule

### test/integer_array_sorter_top_tb.sv
// testbench of the integer array sorter: sends sets of signed values, predicts
// the ascending drain with its overflow flag and checks every result
// depends on isort_pkg and integer_array_sorter_top
`timescale 1ns / 1ps

module integer_array_sorter_top_tb;

    localparam int SET_SIZE = 64;
    localparam int SETTLE_CYCLES = SET_SIZE + 8;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        isort_pkg::t_value value;
        logic              last;
        logic              overflow;
    } t_sorted_result;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    isort_pkg::t_value i_value = '0;
    logic              i_is_last = 1'b0;
    logic              o_strobe;
    isort_pkg::t_value o_sorted_value;
    logic              o_last_out;
    logic              o_overflowed;

    // sorted copy of the values kept so far in the open set
    isort_pkg::t_value kept_values[SET_SIZE];
    int                kept_count = 0;
    logic              dropped_flag = 1'b0;
    t_sorted_result    expected_sorted_q[$];
    t_sorted_result    exp_result;
    int                mismatch_count = 0;
    int                idle_pct = 0;
    int                drain_wait;

    integer_array_sorter_top #(
        .SET_SIZE(SET_SIZE)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_is_last     (i_is_last),
        .o_strobe      (o_strobe),
        .o_sorted_value(o_sorted_value),
        .o_last_out    (o_last_out),
        .o_overflowed  (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("integer_array_sorter_top_tb failed");
        $finish;
    end

    // keep the set sorted on insertion; the closing request releases it
    function automatic void record_element(input isort_pkg::t_value value,
                                           input logic is_last);
        int             pos;
        t_sorted_result res;
        if (kept_count < SET_SIZE) begin
            pos = kept_count;
            while (pos > 0 && kept_values[pos-1] > value) begin
                kept_values[pos] = kept_values[pos-1];
                pos--;
            end
            kept_values[pos] = value;
            kept_count++;
        end else begin
            dropped_flag = 1'b1;
        end
        if (is_last) begin
            for (int k = 0; k < kept_count; k++) begin
                res.value = kept_values[k];
                res.last = (k == kept_count - 1);
                res.overflow = dropped_flag;
                expected_sorted_q.push_back(res);
            end
            kept_count = 0;
            dropped_flag = 1'b0;
        end
    endfunction

    function automatic isort_pkg::t_value rand_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return '0;
                default: return '1;
            endcase
        end else if (sel < 40) begin
            return $signed($urandom_range(16)) - 8;
        end
        return $urandom();
    endfunction

    task automatic send_request(input isort_pkg::t_value value, input logic is_last);
        int gap;
        start <= 1'b1;
        i_value <= value;
        i_is_last <= is_last;
        do @(posedge i_clk); while (busy);
        record_element(value, is_last);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            i_value <= $urandom();
            i_is_last <= 1'($urandom_range(1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_set(input int count);
        for (int k = 0; k < count; k++) begin
            send_request(rand_value(), k == count - 1);
        end
    endtask

    task automatic test_extremes();
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request('0, 1'b0);
        send_request('1, 1'b0);
        send_request(32'sd1, 1'b0);
        send_request(32'sh8000_0001, 1'b0);
        send_request(32'sh7FFF_FFFE, 1'b1);
    endtask

    task automatic test_single_element();
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_duplicates();
        send_request(32'sd5, 1'b0);
        send_request(-32'sd3, 1'b0);
        send_request(32'sd5, 1'b0);
        send_request(32'sd5, 1'b0);
        send_request(-32'sd3, 1'b0);
        send_request('0, 1'b1);
    endtask

    task automatic test_descending();
        for (int k = 0; k < 8; k++) begin
            send_request(32'sd1000 - k * 300, k == 7);
        end
    endtask

    // exactly full, then overflow with the closing request itself dropped
    task automatic test_full_and_overflow();
        send_set(SET_SIZE);
        send_set(SET_SIZE + 1);
        send_set(SET_SIZE + 3);
    endtask

    task automatic test_random_sets(input int pct, input int item_goal);
        int sent;
        int sel;
        int count;
        idle_pct = pct;
        sent = 0;
        while (sent < item_goal) begin
            sel = $urandom_range(99);
            if (sel < 70) count = $urandom_range(1, 8);
            else if (sel < 90) count = $urandom_range(9, 40);
            else if (sel < 97) count = SET_SIZE;
            else count = $urandom_range(SET_SIZE + 1, SET_SIZE + 4);
            send_set(count);
            sent += count;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_sorted_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %0d last %0b",
                         $time, o_sorted_value, o_last_out);
                mismatch_count++;
            end else begin
                exp_result = expected_sorted_q.pop_front();
                if (o_sorted_value !== exp_result.value || o_last_out !== exp_result.last
                    || o_overflowed !== exp_result.overflow) begin
                    $display("%0t: mismatch: expected value %0d last %0b overflow %0b,",
                             $time, exp_result.value, exp_result.last, exp_result.overflow);
                    $display("%0t:           got value %0d last %0b overflow %0b",
                             $time, o_sorted_value, o_last_out, o_overflowed);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 0;
        test_extremes();
        test_single_element();
        test_duplicates();
        test_descending();
        test_full_and_overflow();
        test_random_sets(0, 50);
        test_random_sets(60, 50);
        test_random_sets(15, 50);
        start <= 1'b0;
        @(posedge i_clk);
        drain_wait = 0;
        while (expected_sorted_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_sorted_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived, first value %0d",
                     $time, expected_sorted_q.size(), expected_sorted_q[0].value);
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("integer_array_sorter_top_tb passed");
        end else begin
            $display("integer_array_sorter_top_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/isort_pkg.sv
rtl/isort_cell.sv
rtl/integer_array_sorter_top.sv
test/integer_array_sorter_top_tb.sv
